// ===== rtl/bpp_pkg.sv =====
package bpp_pkg;

  localparam int Q_W    = 32;
  localparam int PROD_W = 64;
  localparam int RND_W  = 48;
  localparam int SAT_W  = 66;
  localparam int DEN_W  = 49;
  localparam int NUM_W  = 50;
  localparam int QUO_W  = 18;
  localparam int S_W    = QUO_W + 1;
  localparam int DRIFT_W = 31;
  localparam int NAX    = 3;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] REG_KICK  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DRIFT = 1'b1;

  localparam int IN_W  = 12 * Q_W;
  localparam int OUT_W = 6 * Q_W;

  // neighbor axes for the cross products
  localparam int NX1 [NAX] = '{1, 2, 0};
  localparam int NX2 [NAX] = '{2, 0, 1};

  localparam logic signed [SAT_W-1:0] QMAX = {{(SAT_W-Q_W){1'b0}}, 32'h7fff_ffff};
  localparam logic signed [SAT_W-1:0] QMIN = {{(SAT_W-Q_W){1'b1}}, 32'h8000_0000};

  typedef logic signed [Q_W-1:0]    q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic signed [SAT_W-1:0]  wide_t;
  typedef logic signed [S_W-1:0]    s_t;

  typedef struct {
    q_t    pos [NAX];
    q_t    vel [NAX];
    prod_t pe  [NAX];
    prod_t pb  [NAX];
  } st_mul_t;

  typedef struct {
    q_t   pos [NAX];
    rnd_t h   [NAX];
    q_t   vm  [NAX];
    q_t   t   [NAX];
  } st_rnd_t;

  typedef struct {
    q_t    pos [NAX];
    rnd_t  h   [NAX];
    q_t    vm  [NAX];
    q_t    t   [NAX];
    prod_t tt  [NAX];
    prod_t ca  [NAX];
    prod_t cb  [NAX];
  } st_sq_t;

  typedef struct {
    q_t               pos [NAX];
    rnd_t             h   [NAX];
    q_t               vm  [NAX];
    q_t               t   [NAX];
    q_t               vp  [NAX];
    logic [DEN_W-1:0] den;
  } st_vp_t;

  typedef struct {
    q_t               pos  [NAX];
    rnd_t             h    [NAX];
    q_t               vm   [NAX];
    q_t               vp   [NAX];
    logic             tneg [NAX];
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] rem  [NAX];
    logic [QUO_W-1:0] quo  [NAX];
  } st_div_t;

  typedef struct {
    q_t    pos [NAX];
    rnd_t  h   [NAX];
    q_t    vm  [NAX];
    prod_t pa  [NAX];
    prod_t pb  [NAX];
  } st_smul_t;

  typedef struct {
    q_t pos [NAX];
    q_t vn  [NAX];
  } st_vn_t;

  typedef struct {
    q_t    pos [NAX];
    q_t    vn  [NAX];
    prod_t pd  [NAX];
  } st_dmul_t;

  typedef struct {
    q_t npos [NAX];
    q_t nvel [NAX];
  } st_out_t;

  // Q16.16 product rounded half up
  function automatic rnd_t qround(input prod_t p);
    prod_t a;
    a = p + prod_t'(32768);
    return a[PROD_W-1:PROD_W-RND_W];
  endfunction

  function automatic q_t sat32(input wide_t v);
    if (v > QMAX) return q_t'(QMAX[Q_W-1:0]);
    if (v < QMIN) return q_t'(QMIN[Q_W-1:0]);
    return v[Q_W-1:0];
  endfunction

endpackage

// ===== rtl/boris_particle_push.sv =====
// channel | dir | fields (low bit up)
// in_     | in  | pos_x,y,z, vel_x,y,z, efield_x,y,z, bfield_x,y,z (32 b each)
// out_    | out | new_pos_x,y,z, new_vel_x,y,z (32 b each)
// cfg_    | in  | index 0 kick_factor (s32), index 1 drift_factor (u31)
// One item per cycle while out_ is not stalled; 27 register stages. Depth is set by
// the 18-stage restoring divider for s = 2t/(1+|t|^2), plus its setup stage.
// Synchronous active-low reset clears valids and configuration.
// A stall on out_ holds only stages that are full; bubbles close up.
module boris_particle_push (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bpp_pkg::IN_W-1:0]      in_tdata,  // pos xyz, vel xyz, efield xyz, bfield xyz
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bpp_pkg::OUT_W-1:0]     out_tdata, // new_pos xyz, new_vel xyz
  input  logic                          cfg_we,
  input  logic [bpp_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [bpp_pkg::CFG_DW-1:0]    cfg_wdata
);
  import bpp_pkg::*;

  localparam int ST_MUL  = 0;
  localparam int ST_RND  = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_VP   = 3;
  localparam int ST_PRE  = 4;
  localparam int ST_SMUL = ST_PRE + QUO_W + 1;
  localparam int ST_VN   = ST_SMUL + 1;
  localparam int ST_DMUL = ST_VN + 1;
  localparam int ST_OUT  = ST_DMUL + 1;
  localparam int N_ST    = ST_OUT + 1;

  q_t                 kick_r;
  logic [DRIFT_W-1:0] drift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kick_r  <= '0;
      drift_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_KICK:  kick_r  <= cfg_wdata;
        REG_DRIFT: drift_r <= cfg_wdata[DRIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // valid chain; a stage moves when it is empty or the next one moves
  logic [N_ST-1:0] v_r, en, v_in;

  always_comb begin
    en[N_ST-1] = !v_r[N_ST-1] || out_tready;
    for (int i = N_ST - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign v_in = {v_r[N_ST-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < N_ST; i++) if (en[i]) v_r[i] <= v_in[i];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[N_ST-1];

  st_mul_t  mul_r,  mul_nxt;
  st_rnd_t  rnd_r,  rnd_nxt;
  st_sq_t   sq_r,   sq_nxt;
  st_vp_t   vp_r,   vp_nxt;
  st_div_t  div_r  [QUO_W+1];
  st_div_t  div_nxt[QUO_W+1];
  st_smul_t smul_r, smul_nxt;
  st_vn_t   vn_r,   vn_nxt;
  st_dmul_t dmul_r, dmul_nxt;
  st_out_t  out_r,  out_nxt;

  // field products with kick factor
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      mul_nxt.pos[i] = in_tdata[Q_W*i +: Q_W];
      mul_nxt.vel[i] = in_tdata[Q_W*(3+i) +: Q_W];
      mul_nxt.pe[i]  = kick_r * q_t'(in_tdata[Q_W*(6+i) +: Q_W]);
      mul_nxt.pb[i]  = kick_r * q_t'(in_tdata[Q_W*(9+i) +: Q_W]);
    end
  end

  // half kick, v-, t
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      rnd_nxt.pos[i] = mul_r.pos[i];
      rnd_nxt.h[i]   = qround(mul_r.pe[i]);
      rnd_nxt.vm[i]  = sat32(wide_t'(mul_r.vel[i]) + wide_t'(rnd_nxt.h[i]));
      rnd_nxt.t[i]   = sat32(wide_t'(qround(mul_r.pb[i])));
    end
  end

  // |t|^2 terms and v- x t products
  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      sq_nxt.pos[i] = rnd_r.pos[i];
      sq_nxt.h[i]   = rnd_r.h[i];
      sq_nxt.vm[i]  = rnd_r.vm[i];
      sq_nxt.t[i]   = rnd_r.t[i];
      sq_nxt.tt[i]  = rnd_r.t[i] * rnd_r.t[i];
      sq_nxt.ca[i]  = rnd_r.vm[NX1[i]] * rnd_r.t[NX2[i]];
      sq_nxt.cb[i]  = rnd_r.vm[NX2[i]] * rnd_r.t[NX1[i]];
    end
  end

  // v' and denominator 1 + |t|^2
  always_comb begin
    vp_nxt.den = DEN_W'(65536) + DEN_W'(qround(sq_r.tt[0])) + DEN_W'(qround(sq_r.tt[1]))
               + DEN_W'(qround(sq_r.tt[2]));
    for (int i = 0; i < NAX; i++) begin
      vp_nxt.pos[i] = sq_r.pos[i];
      vp_nxt.h[i]   = sq_r.h[i];
      vp_nxt.vm[i]  = sq_r.vm[i];
      vp_nxt.t[i]   = sq_r.t[i];
      vp_nxt.vp[i]  = sat32(wide_t'(sq_r.vm[i]) + wide_t'(qround(sq_r.ca[i]))
                          - wide_t'(qround(sq_r.cb[i])));
    end
  end

  // divider setup: numerator |t|*2^17 + den/2, round to nearest
  always_comb begin
    logic [Q_W-1:0] tabs;
    div_nxt[0].den = vp_r.den;
    for (int i = 0; i < NAX; i++) begin
      tabs = vp_r.t[i][Q_W-1] ? (~vp_r.t[i] + 1'b1) : vp_r.t[i];
      div_nxt[0].pos[i]  = vp_r.pos[i];
      div_nxt[0].h[i]    = vp_r.h[i];
      div_nxt[0].vm[i]   = vp_r.vm[i];
      div_nxt[0].vp[i]   = vp_r.vp[i];
      div_nxt[0].tneg[i] = vp_r.t[i][Q_W-1];
      div_nxt[0].rem[i]  = NUM_W'({tabs, 17'b0}) + NUM_W'(vp_r.den >> 1);
      div_nxt[0].quo[i]  = '0;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int BIT = QUO_W - 1 - k;
    always_comb begin
      div_nxt[k+1] = div_r[k];
      for (int i = 0; i < NAX; i++) begin
        if ((div_r[k].rem[i] >> BIT) >= NUM_W'(div_r[k].den)) begin
          div_nxt[k+1].rem[i]      = div_r[k].rem[i] - (NUM_W'(div_r[k].den) << BIT);
          div_nxt[k+1].quo[i][BIT] = 1'b1;
        end
      end
    end
  end

  // v' x s products
  always_comb begin
    s_t s [NAX];
    for (int i = 0; i < NAX; i++) begin
      s[i] = div_r[QUO_W].tneg[i] ? -s_t'({1'b0, div_r[QUO_W].quo[i]})
                                   :  s_t'({1'b0, div_r[QUO_W].quo[i]});
    end
    for (int i = 0; i < NAX; i++) begin
      smul_nxt.pos[i] = div_r[QUO_W].pos[i];
      smul_nxt.h[i]   = div_r[QUO_W].h[i];
      smul_nxt.vm[i]  = div_r[QUO_W].vm[i];
      smul_nxt.pa[i]  = div_r[QUO_W].vp[NX1[i]] * s[NX2[i]];
      smul_nxt.pb[i]  = div_r[QUO_W].vp[NX2[i]] * s[NX1[i]];
    end
  end

  // v+ and second half kick
  always_comb begin
    q_t vplus;
    for (int i = 0; i < NAX; i++) begin
      vplus = sat32(wide_t'(smul_r.vm[i]) + wide_t'(qround(smul_r.pa[i]))
                  - wide_t'(qround(smul_r.pb[i])));
      vn_nxt.pos[i] = smul_r.pos[i];
      vn_nxt.vn[i]  = sat32(wide_t'(vplus) + wide_t'(smul_r.h[i]));
    end
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      dmul_nxt.pos[i] = vn_r.pos[i];
      dmul_nxt.vn[i]  = vn_r.vn[i];
      dmul_nxt.pd[i]  = vn_r.vn[i] * q_t'({1'b0, drift_r});
    end
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      out_nxt.nvel[i] = dmul_r.vn[i];
      out_nxt.npos[i] = sat32(wide_t'(dmul_r.pos[i]) + wide_t'(qround(dmul_r.pd[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MUL])  mul_r  <= mul_nxt;
    if (en[ST_RND])  rnd_r  <= rnd_nxt;
    if (en[ST_SQ])   sq_r   <= sq_nxt;
    if (en[ST_VP])   vp_r   <= vp_nxt;
    for (int k = 0; k <= QUO_W; k++) if (en[ST_PRE+k]) div_r[k] <= div_nxt[k];
    if (en[ST_SMUL]) smul_r <= smul_nxt;
    if (en[ST_VN])   vn_r   <= vn_nxt;
    if (en[ST_DMUL]) dmul_r <= dmul_nxt;
    if (en[ST_OUT])  out_r  <= out_nxt;
  end

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      out_tdata[Q_W*i +: Q_W]     = out_r.npos[i];
      out_tdata[Q_W*(3+i) +: Q_W] = out_r.nvel[i];
    end
  end

endmodule

// ===== rtl/bpp_chk.sv =====
module bpp_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [bpp_pkg::OUT_W-1:0] out_tdata
);

  // pipeline drains freely when the result side is not holding
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped during stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed during stall");

endmodule

bind boris_particle_push bpp_chk u_bpp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tb_boris_particle_push.sv =====
class push_scoreboard;
  logic [191:0] pending[$];
  int errors;
  longint kick;
  longint drift;

  function new();
    errors = 0;
    kick = 0;
    drift = 0;
  endfunction

  static function longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product, round half up (floor of (a*b + 2^15) / 2^16)
  static function longint qmul(longint a, longint b);
    longint v;
    v = a * b + 32768;
    return v >>> 16;
  endfunction

  static function longint qscale(longint t, longint d);
    longint m;
    longint q;
    m = (t < 0 ? -t : t) <<< 17;
    q = (m + d / 2) / d;
    return t < 0 ? -q : q;
  endfunction

  function void note_particle(logic [383:0] d);
    longint pos[3], vel[3], ef[3], bf[3], h[3], vm[3], tv[3], sv[3];
    longint vp[3], vq[3], vn[3], pn[3];
    longint tsq, den;
    logic [191:0] r;
    tsq = 0;
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'($signed(d[32*i +: 32]));
      vel[i] = longint'($signed(d[32*(3+i) +: 32]));
      ef[i] = longint'($signed(d[32*(6+i) +: 32]));
      bf[i] = longint'($signed(d[32*(9+i) +: 32]));
    end
    for (int i = 0; i < 3; i++) begin
      h[i] = qmul(kick, ef[i]);
      vm[i] = sat(vel[i] + h[i]);
      tv[i] = sat(qmul(kick, bf[i]));
      tsq += qmul(tv[i], tv[i]);
    end
    den = 65536 + tsq;
    for (int i = 0; i < 3; i++) sv[i] = qscale(tv[i], den);
    for (int i = 0; i < 3; i++)
      vp[i] = sat(vm[i] + qmul(vm[(i+1)%3], tv[(i+2)%3]) - qmul(vm[(i+2)%3], tv[(i+1)%3]));
    for (int i = 0; i < 3; i++)
      vq[i] = sat(vm[i] + qmul(vp[(i+1)%3], sv[(i+2)%3]) - qmul(vp[(i+2)%3], sv[(i+1)%3]));
    for (int i = 0; i < 3; i++) begin
      vn[i] = sat(vq[i] + h[i]);
      pn[i] = sat(pos[i] + qmul(vn[i], drift));
      r[32*i +: 32] = pn[i][31:0];
      r[32*(3+i) +: 32] = vn[i][31:0];
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [191:0] got);
    logic [191:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected item %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    for (int f = 0; f < 6; f++)
      if (got[32*f +: 32] !== want[32*f +: 32]) begin
        $display("%0t: field %0d expected %h actual %h", $time, f,
                 want[32*f +: 32], got[32*f +: 32]);
        errors++;
      end
  endfunction
endclass

module tb_boris_particle_push;
  import bpp_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_addr = REG_KICK;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  int stall_mode = 0;

  push_scoreboard sb = new();

  boris_particle_push dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_particle(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // receiver stall pattern, changes character now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [31:0] rand_q(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
      2: return 32'($signed($urandom_range(0, 65536)) - 32768);
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200);
    endcase
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_KICK) sb.kick = longint'($signed(val));
    else sb.drift = longint'(val[30:0]);
    @(posedge clk);
  endtask

  task automatic send_particle(logic [IN_W-1:0] d);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic idle_gap();
    in_tvalid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic [IN_W-1:0] d;
    int mode, burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 1)) idle_gap();
        burst = $urandom_range(1, 30);
      end
      burst--;
      mode = $urandom_range(0, 4);
      for (int f = 0; f < 12; f++)
        d[32*f +: 32] = $urandom_range(0, 9) == 0 ? rand_q($urandom_range(0, 4)) : rand_q(mode);
      send_particle(d);
    end
  endtask

  initial begin
    logic [IN_W-1:0] d;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers are zero: output equals input velocity/position
    d = '0;
    send_particle(d);
    d = '1;
    send_particle(d);
    for (int f = 0; f < 12; f++) d[32*f +: 32] = f[0] ? 32'h7fff_ffff : 32'h8000_0000;
    send_particle(d);
    drain();

    write_reg(REG_KICK, 32'h0001_0000);
    write_reg(REG_DRIFT, 32'h0000_8000);
    for (int f = 0; f < 12; f++) d[32*f +: 32] = 32'h0001_0000 * (f % 4);
    send_particle(d);
    for (int f = 0; f < 12; f++) d[32*f +: 32] = 32'h7fff_ffff;
    send_particle(d);
    for (int f = 0; f < 12; f++) d[32*f +: 32] = 32'h8000_0000;
    send_particle(d);
    d = '0;
    d[32*11 +: 32] = 32'h0001_0000;
    d[32*3 +: 32] = 32'h0001_0000;
    send_particle(d);
    d = '1;
    send_particle(d);
    drain();

    // extreme registers, including the unused high bit of drift
    write_reg(REG_KICK, 32'h8000_0000);
    write_reg(REG_DRIFT, 32'hffff_ffff);
    random_phase(60);
    drain();
    write_reg(REG_KICK, 32'h7fff_ffff);
    write_reg(REG_DRIFT, 32'h7fff_ffff);
    random_phase(60);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_KICK, ph[0] ? $urandom() : 32'($signed($urandom_range(0, 131072)) - 65536));
      write_reg(REG_DRIFT, ph[1] ? $urandom() : $urandom_range(0, 131072));
      random_phase(230);
      drain();
    end

    if (sb.errors == 0) $display("boris_particle_push test passed");
    else $display("boris_particle_push test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("boris_particle_push test failed");
    $finish;
  end
endmodule
